// ===== hdl/bae_pkg.sv =====
// ============================================================================
// bae_pkg - shared types and constants of the boolean arithmetic encoder
// Request modes, coder and byte emitter commands, and the status records
// that pass between the sequencer and its two working units.
// ============================================================================
package bae_pkg;

   localparam int MODE_W    = 2;
   localparam int PROB_W    = 8;
   localparam int LIT_W     = 32;
   localparam int LEN_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int RANGE_W   = 8;
   localparam int BOTTOM_W  = 32;
   localparam int SHCNT_W   = 5;
   localparam int REL_CNT_W = 6;

   localparam logic [RANGE_W-1:0]  RANGE_INIT  = 8'd255;
   localparam logic [SHCNT_W-1:0]  SHCNT_INIT  = 5'd24;
   localparam logic [SHCNT_W-1:0]  SHCNT_BYTE  = 5'd8;
   localparam logic [SHCNT_W-1:0]  SHCNT_MAX   = 5'd24;
   localparam logic [PROB_W-1:0]   HALF_PROB   = 8'd128;
   localparam logic [BOTTOM_W-1:0] LOW_MASK    = 32'h00FF_FFFF;
   localparam logic [LEN_W-1:0]    LIT_MAX     = 6'd32;
   localparam logic [REL_CNT_W-1:0] REL_CAP    = 6'd32;
   localparam logic [BYTE_W-1:0]   BYTE_ONES   = 8'hFF;
   localparam logic [BYTE_W-1:0]   BYTE_ZERO   = 8'h00;
   localparam logic [BYTE_W-1:0]   BYTE_TOP    = 8'hFE;
   localparam int                  FLUSH_BYTES = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_BIT    = 2'd0,
      MODE_LIT    = 2'd1,
      MODE_FINISH = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      C_NOP   = 3'd0,
      C_CODE  = 3'd1,
      C_NORM  = 3'd2,
      C_ALIGN = 3'd3,
      C_BYTE  = 3'd4,
      C_CLEAR = 3'd5
   } coder_op_type;

   typedef enum logic [2:0] {
      EOP_NONE  = 3'd0,
      EOP_CARRY = 3'd1,
      EOP_PUSH  = 3'd2,
      EOP_FLUSH = 3'd3,
      EOP_CLOSE = 3'd4
   } emit_op_type;

   typedef struct packed {
      coder_op_type      op;
      logic [PROB_W-1:0] prob;
      logic              bit_value;
   } coder_cmd_type;

   typedef struct packed {
      logic              range_low;
      logic              top_bit;
      logic              push_due;
      logic              fin_carry;
      logic [BYTE_W-1:0] norm_byte;
      logic [BYTE_W-1:0] fin_byte;
   } coder_stat_type;

   typedef struct packed {
      emit_op_type       op;
      logic [BYTE_W-1:0] data;
   } emit_cmd_type;

   typedef struct packed {
      logic busy;
      logic err;
   } emit_stat_type;

endpackage

// ===== hdl/bae_if.sv =====
// ============================================================================
// bae_if - request and response channels of the boolean arithmetic encoder
// Valid/ready channels; a transfer happens when valid and ready are high.
// ============================================================================
interface bae_req_if import bae_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PROB_W-1:0] prob;
   logic              bit_value;
   logic [LIT_W-1:0]  literal_value;
   logic [LEN_W-1:0]  literal_len;

   modport source (output valid, mode, prob, bit_value, literal_value, literal_len,
                   input ready);
   modport sink   (input valid, mode, prob, bit_value, literal_value, literal_len,
                   output ready);
endinterface

interface bae_rsp_if import bae_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic              error;

   modport source (output valid, out_byte, last, error, input ready);
   modport sink   (input valid, out_byte, last, error, output ready);
endinterface

// ===== hdl/boolean_arithmetic_encoder_top.sv =====
// Flow: a bit request runs one split, then normalization shifts, waiting on the emitter for
//   carries, byte pushes and released bytes; a literal repeats this for each of its bits.
// Finish resolves a tail carry, aligns, pushes FLUSH_BYTES bytes, flushes and closes; mode 3 only closes.
// Throughput: one request at a time; req ready is high only while the sequencer idles and
//   the emitter has closed; the shifter does one bit and the emitter one byte per cycle unless stalled.
// Reset: synchronous, active high; restores range 255, bottom 0, shift count 24.
// ============================================================================
// boolean_arithmetic_encoder_top - binary arithmetic encoder
// Sequencer around a shared range/bottom unit and a carry-resolving byte
// emitter. Codes single bits, literals and the stream finish.
// ============================================================================
module boolean_arithmetic_encoder_top import bae_pkg::*; #(
   parameter int MAX_FF_RUN = 16
) (
   input  logic    clock,
   input  logic    reset,
   bae_req_if.sink   req_bus,
   bae_rsp_if.source rsp_bus
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SPLIT  = 9'b000000010,
      S_NORM   = 9'b000000100,
      S_WAIT   = 9'b000001000,
      S_FCHK   = 9'b000010000,
      S_FALIGN = 9'b000100000,
      S_FBYTE  = 9'b001000000,
      S_FFLUSH = 9'b010000000,
      S_CLOSE  = 9'b100000000
   } state_type;

   localparam int FCW = $clog2(FLUSH_BYTES);

   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;
   logic              lit_mode_ff, lit_mode_in;
   logic [PROB_W-1:0] prob_ff, prob_in;
   logic              bit_ff, bit_in;
   logic [LIT_W-1:0]  lit_ff, lit_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              carried_ff, carried_in;
   logic [FCW-1:0]    fcnt_ff, fcnt_in;
   logic              drain_ff, drain_in;

   coder_cmd_type  ccmd;
   coder_stat_type cstat;
   emit_cmd_type   ecmd;
   emit_stat_type  estat;

   logic             accept;
   logic [LEN_W-1:0] len_clamp;

   bae_coder u_coder (
      .clock (clock),
      .reset (reset),
      .cmd   (ccmd),
      .stat  (cstat)
   );

   bae_emit #(
      .MAX_FF_RUN (MAX_FF_RUN)
   ) u_emit (
      .clock (clock),
      .reset (reset),
      .cmd   (ecmd),
      .stat  (estat),
      .rsp   (rsp_bus)
   );

   // take a request only when the previous one has fully closed
   assign req_bus.ready = (state_ff == S_IDLE) && !drain_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign len_clamp     = (req_bus.literal_len > LIT_MAX) ? LIT_MAX : req_bus.literal_len;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      lit_mode_in = lit_mode_ff;
      prob_in     = prob_ff;
      bit_in      = bit_ff;
      lit_in      = lit_ff;
      len_in      = len_ff;
      carried_in  = carried_ff;
      fcnt_in     = fcnt_ff;
      drain_in    = drain_ff;

      ccmd.op        = C_NOP;
      ccmd.prob      = lit_mode_ff ? HALF_PROB : prob_ff;
      ccmd.bit_value = lit_mode_ff ? lit_ff[5'(len_ff - LEN_W'(1))] : bit_ff;
      ecmd.op        = EOP_NONE;
      ecmd.data      = cstat.norm_byte;

      case (state_ff)
         S_IDLE: begin
            // hold ready low until the emitter has closed the last request
            if (drain_ff) begin
               if (!estat.busy) begin
                  drain_in = 1'b0;
               end
            end else if (accept) begin
               if (estat.err) begin
                  // sticky error: answer with the marker alone
                  state_in = S_CLOSE;
               end else begin
                  case (req_bus.mode)
                     MODE_BIT: begin
                        prob_in     = req_bus.prob;
                        bit_in      = req_bus.bit_value;
                        lit_mode_in = 1'b0;
                        state_in    = S_SPLIT;
                     end
                     MODE_LIT: begin
                        lit_in      = req_bus.literal_value;
                        len_in      = len_clamp;
                        lit_mode_in = 1'b1;
                        state_in    = (len_clamp == '0) ? S_CLOSE : S_SPLIT;
                     end
                     MODE_FINISH: begin
                        state_in = S_FCHK;
                     end
                     default: begin
                        state_in = S_CLOSE;
                     end
                  endcase
               end
            end
         end
         S_SPLIT: begin
            // one split multiply per coded bit
            ccmd.op    = C_CODE;
            carried_in = 1'b0;
            if (lit_mode_ff) begin
               len_in = len_ff - LEN_W'(1);
            end
            state_in = S_NORM;
         end
         S_NORM: begin
            if (!cstat.range_low) begin
               state_in = (lit_mode_ff && (len_ff != '0)) ? S_SPLIT : S_CLOSE;
            end else if (cstat.top_bit && !carried_ff) begin
               // resolve the carry before the bit leaves bottom
               ecmd.op    = EOP_CARRY;
               carried_in = 1'b1;
               ret_in     = S_NORM;
               state_in   = S_WAIT;
            end else begin
               ccmd.op    = C_NORM;
               carried_in = 1'b0;
               if (cstat.push_due) begin
                  ecmd.op   = EOP_PUSH;
                  ecmd.data = cstat.norm_byte;
                  ret_in    = S_NORM;
                  state_in  = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (!estat.busy) begin
               state_in = estat.err ? S_CLOSE : ret_ff;
            end
         end
         S_FCHK: begin
            if (cstat.fin_carry) begin
               ecmd.op  = EOP_CARRY;
               ret_in   = S_FALIGN;
               state_in = S_WAIT;
            end else begin
               state_in = S_FALIGN;
            end
         end
         S_FALIGN: begin
            // shift the tail up by the pending count
            ccmd.op  = C_ALIGN;
            fcnt_in  = '0;
            state_in = S_FBYTE;
         end
         S_FBYTE: begin
            ccmd.op   = C_BYTE;
            ecmd.op   = EOP_PUSH;
            ecmd.data = cstat.fin_byte;
            fcnt_in   = fcnt_ff + FCW'(1);
            ret_in    = (fcnt_ff == FCW'(FLUSH_BYTES - 1)) ? S_FFLUSH : S_FBYTE;
            state_in  = S_WAIT;
         end
         S_FFLUSH: begin
            // drain held byte and run, and return the coder to reset values
            ccmd.op  = C_CLEAR;
            ecmd.op  = EOP_FLUSH;
            ret_in   = S_CLOSE;
            state_in = S_WAIT;
         end
         S_CLOSE: begin
            ecmd.op  = EOP_CLOSE;
            drain_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         carried_ff <= 1'b0;
         fcnt_ff    <= '0;
         drain_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         carried_ff <= carried_in;
         fcnt_ff    <= fcnt_in;
         drain_ff   <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_mode_ff <= lit_mode_in;
      prob_ff     <= prob_in;
      bit_ff      <= bit_in;
      lit_ff      <= lit_in;
      len_ff      <= len_in;
   end

   // the emitter only takes a command while it is idle
   assert property (@(posedge clock) disable iff (reset)
      (ecmd.op != EOP_NONE) |-> !estat.busy)
      else $error("emitter command issued while busy");

   // a request is accepted only with the emitter idle
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !estat.busy)
      else $error("request accepted while emitter busy");

   // the error state never clears short of reset
   assert property (@(posedge clock) disable iff (reset)
      estat.err |=> estat.err)
      else $error("error flag dropped");

   // between requests the range is normalized unless coding has failed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !estat.err) |-> !cstat.range_low)
      else $error("range left unnormalized");

endmodule

// ===== hdl/bae_coder.sv =====
// ============================================================================
// bae_coder - range/bottom arithmetic unit
// Holds range, bottom and shift count; one split multiply and one shared
// left shifter serve bit coding, normalization and the finish alignment.
// ============================================================================
module bae_coder import bae_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  coder_cmd_type  cmd,
   output coder_stat_type stat
);

   logic [RANGE_W-1:0]  range_ff, range_in;
   logic [BOTTOM_W-1:0] bottom_ff, bottom_in;
   logic [SHCNT_W-1:0]  shcnt_ff, shcnt_in;

   logic [SHCNT_W-1:0]    shcnt_eff;
   logic [SHCNT_W-1:0]    shamt;
   logic [SHCNT_W-1:0]    shcnt_dec;
   logic [SHCNT_W-1:0]    fin_idx;
   logic [BOTTOM_W-1:0]   shifted;
   logic [2*RANGE_W-1:0]  prod;
   logic [RANGE_W-1:0]    split;

   always_comb begin
      // the guard only matters for counts that never occur
      shcnt_eff = ((shcnt_ff == '0) || (shcnt_ff > SHCNT_MAX)) ? SHCNT_MAX : shcnt_ff;
      fin_idx   = SHCNT_W'(6'd32 - {1'b0, shcnt_eff});
      case (cmd.op)
         C_NORM:  shamt = SHCNT_W'(1);
         C_ALIGN: shamt = shcnt_eff;
         default: shamt = SHCNT_W'(BYTE_W);
      endcase
      shifted   = bottom_ff << shamt;
      prod      = (range_ff - RANGE_W'(1)) * cmd.prob;
      split     = RANGE_W'(1) + prod[2*RANGE_W-1:RANGE_W];
      shcnt_dec = shcnt_ff - SHCNT_W'(1);
   end

   always_comb begin
      range_in  = range_ff;
      bottom_in = bottom_ff;
      shcnt_in  = shcnt_ff;
      case (cmd.op)
         C_CODE: begin
            if (cmd.bit_value) begin
               bottom_in = bottom_ff + BOTTOM_W'(split);
               range_in  = range_ff - split;
            end else begin
               range_in  = split;
            end
         end
         C_NORM: begin
            range_in  = {range_ff[RANGE_W-2:0], 1'b0};
            bottom_in = shifted;
            shcnt_in  = shcnt_dec;
            if (shcnt_dec == '0) begin
               bottom_in = shifted & LOW_MASK;
               shcnt_in  = SHCNT_BYTE;
            end
         end
         C_ALIGN, C_BYTE: begin
            bottom_in = shifted;
         end
         C_CLEAR: begin
            range_in  = RANGE_INIT;
            bottom_in = '0;
            shcnt_in  = SHCNT_INIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= RANGE_INIT;
         bottom_ff <= '0;
         shcnt_ff  <= SHCNT_INIT;
      end else begin
         range_ff  <= range_in;
         bottom_ff <= bottom_in;
         shcnt_ff  <= shcnt_in;
      end
   end

   assign stat.range_low = ~range_ff[RANGE_W-1];
   assign stat.top_bit   = bottom_ff[BOTTOM_W-1];
   assign stat.push_due  = (shcnt_ff == SHCNT_W'(1));
   assign stat.fin_carry = bottom_ff[fin_idx];
   assign stat.norm_byte = bottom_ff[BOTTOM_W-2:BOTTOM_W-1-BYTE_W];
   assign stat.fin_byte  = bottom_ff[BOTTOM_W-1:BOTTOM_W-BYTE_W];

endmodule

// ===== hdl/bae_emit.sv =====
// ============================================================================
// bae_emit - carry resolution and byte output
// Keeps the held byte and the 0xFF run, releases bytes one per cycle while the
// output is free, and delays each byte one slot to mark a request's last byte.
// ============================================================================
module bae_emit import bae_pkg::*; #(
   parameter int MAX_FF_RUN = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  emit_cmd_type  cmd,
   output emit_stat_type stat,
   bae_rsp_if.source     rsp
);

   localparam int RCW = $clog2(MAX_FF_RUN + 2);

   typedef enum logic [2:0] {
      E_IDLE  = 3'b001,
      E_REL   = 3'b010,
      E_CLOSE = 3'b100
   } estate_type;

   estate_type           state_ff, state_in;
   logic [BYTE_W-1:0]    held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   logic [RCW-1:0]       run_ff, run_in;
   logic                 err_ff, err_in;
   logic [BYTE_W-1:0]    rel_byte_ff, rel_byte_in;
   logic [BYTE_W-1:0]    fill_ff, fill_in;
   logic [RCW-1:0]       rel_left_ff, rel_left_in;
   logic [REL_CNT_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic [BYTE_W-1:0]    pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_err_ff, out_err_in;
   logic                 out_valid_ff, out_valid_in;

   logic           out_free;
   logic           advance;
   logic [RCW-1:0] rel_total;

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      run_in        = run_ff;
      err_in        = err_ff;
      rel_byte_in   = rel_byte_ff;
      fill_in       = fill_ff;
      rel_left_in   = rel_left_ff;
      rel_cnt_in    = rel_cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;
      out_valid_in  = out_valid_ff;
      advance       = 1'b0;

      out_free  = ~out_valid_ff | rsp.ready;
      rel_total = RCW'(held_valid_ff) + run_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         E_IDLE: begin
            case (cmd.op)
               EOP_CARRY: begin
                  if (!held_valid_ff) begin
                     err_in = 1'b1;
                  end else if (run_ff != '0) begin
                     // held byte plus one, then the run turns into zeros
                     rel_byte_in = held_ff + BYTE_W'(1);
                     fill_in     = BYTE_ZERO;
                     rel_left_in = run_ff;
                     state_in    = E_REL;
                     held_in     = '0;
                     run_in      = '0;
                  end else if (held_ff >= BYTE_TOP) begin
                     held_in       = '0;
                     held_valid_in = 1'b0;
                     run_in        = RCW'(1);
                  end else begin
                     held_in = held_ff + BYTE_W'(1);
                  end
               end
               EOP_PUSH: begin
                  if (cmd.data == BYTE_ONES) begin
                     if (run_ff >= RCW'(MAX_FF_RUN)) begin
                        err_in = 1'b1;
                     end else begin
                        run_in = run_ff + RCW'(1);
                     end
                  end else begin
                     rel_byte_in   = held_valid_ff ? held_ff : BYTE_ONES;
                     fill_in       = BYTE_ONES;
                     rel_left_in   = rel_total;
                     if (rel_total != '0) begin
                        state_in = E_REL;
                     end
                     held_in       = cmd.data;
                     held_valid_in = 1'b1;
                     run_in        = '0;
                  end
               end
               EOP_FLUSH: begin
                  rel_byte_in   = held_valid_ff ? held_ff : BYTE_ONES;
                  fill_in       = BYTE_ONES;
                  rel_left_in   = rel_total;
                  if (rel_total != '0) begin
                     state_in = E_REL;
                  end
                  held_in       = '0;
                  held_valid_in = 1'b0;
                  run_in        = '0;
               end
               EOP_CLOSE: begin
                  state_in = E_CLOSE;
               end
               default: begin
               end
            endcase
         end
         E_REL: begin
            if (rel_cnt_ff == REL_CAP) begin
               // drop bytes past the per-request limit
               advance = 1'b1;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_byte_in  = pend_ff;
                  out_last_in  = 1'b0;
                  out_err_in   = 1'b0;
                  out_valid_in = 1'b1;
               end
               pend_in       = rel_byte_ff;
               pend_valid_in = 1'b1;
               rel_cnt_in    = rel_cnt_ff + REL_CNT_W'(1);
               advance       = 1'b1;
            end
            if (advance) begin
               rel_byte_in = fill_ff;
               rel_left_in = rel_left_ff - RCW'(1);
               if (rel_left_ff == RCW'(1)) begin
                  state_in = E_IDLE;
               end
            end
         end
         E_CLOSE: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  out_byte_in   = pend_ff;
                  out_last_in   = ~err_ff;
                  out_err_in    = 1'b0;
                  out_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
                  if (!err_ff) begin
                     state_in   = E_IDLE;
                     rel_cnt_in = '0;
                  end
               end
            end else if (err_ff) begin
               if (out_free) begin
                  out_byte_in  = BYTE_ZERO;
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b1;
                  out_valid_in = 1'b1;
                  state_in     = E_IDLE;
                  rel_cnt_in   = '0;
               end
            end else begin
               state_in   = E_IDLE;
               rel_cnt_in = '0;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= E_IDLE;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         run_ff        <= '0;
         err_ff        <= 1'b0;
         rel_left_ff   <= '0;
         rel_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         run_ff        <= run_in;
         err_ff        <= err_in;
         rel_left_ff   <= rel_left_in;
         rel_cnt_ff    <= rel_cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_byte_ff <= rel_byte_in;
      fill_ff     <= fill_in;
      pend_ff     <= pend_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign stat.busy    = (state_ff != E_IDLE);
   assign stat.err     = err_ff;
   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.last     = out_last_ff;
   assign rsp.error    = out_err_ff;

endmodule
